### rtl/adc_two_bit_channel_statistics_defines.svh
// Assertion macros shared by the RTL of the channel statistics block.
`ifndef ADC_TWO_BIT_CHANNEL_STATISTICS_DEFINES_SVH
`define ADC_TWO_BIT_CHANNEL_STATISTICS_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ADCSTAT_ASSERT_NOW(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ADCSTAT_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

### rtl/adcstat_pkg.sv
`default_nettype none

package adcstat_pkg;

   localparam int VALUE_W = 33;
   localparam int COUNT_W = 30;
   localparam int WORD_W  = 16;

   localparam logic [COUNT_W-1:0] CNT_MAX     = 30'h3FFF_FFFF;
   localparam logic [COUNT_W-1:0] EPOCH_RESET = 30'd33554432;
   localparam logic signed [VALUE_W:0] OFS_MAX =  34'sd3221225469;
   localparam logic signed [VALUE_W:0] OFS_MIN = -34'sd3221225469;

   // Two-bit sample codes, named by the levels they stand for.
   localparam logic [1:0] CODE_P1 = 2'd0;
   localparam logic [1:0] CODE_P3 = 2'd1;
   localparam logic [1:0] CODE_M1 = 2'd2;
   localparam logic [1:0] CODE_M3 = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_RPT_READ,
      ST_RPT_LOAD,
      ST_RPT_SEND
   } state_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clear_all;
   } mem_ctl_type;

   // Codes 0..3 stand for the sample levels +1, +3, -1, -3.
   function automatic logic signed [2:0] code_value(input logic [1:0] code);
      logic signed [2:0] v;
      unique case (code)
         CODE_P1: v = 3'sd1;
         CODE_P3: v = 3'sd3;
         CODE_M1: v = -3'sd1;
         CODE_M3: v = -3'sd3;
         default: v = 3'sd0;
      endcase
      return v;
   endfunction

   function automatic logic [VALUE_W-1:0] hist_inc(input logic [VALUE_W-1:0] old);
      logic [COUNT_W-1:0] cnt;
      cnt = old[COUNT_W-1:0];
      if (cnt != CNT_MAX) begin
         cnt = cnt + 1'b1;
      end
      return {{(VALUE_W-COUNT_W){1'b0}}, cnt};
   endfunction

   function automatic logic [VALUE_W-1:0] ofs_add(input logic [VALUE_W-1:0] old,
                                                  input logic [1:0] code);
      logic signed [VALUE_W:0] sum;
      sum = $signed({old[VALUE_W-1], old}) + (VALUE_W+1)'(code_value(code));
      if (sum > OFS_MAX) begin
         sum = OFS_MAX;
      end else if (sum < OFS_MIN) begin
         sum = OFS_MIN;
      end
      return sum[VALUE_W-1:0];
   endfunction

endpackage

`default_nettype wire

### rtl/adcstat_mem.sv
`default_nettype none

module adcstat_mem
   import adcstat_pkg::*;
#(
   parameter int DEPTH = 20,
   parameter int AW    = 5
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire mem_ctl_type        ctl,
   input  wire logic [AW-1:0]      rd_addr,
   input  wire logic [AW-1:0]      wr_addr,
   input  wire logic [VALUE_W-1:0] wr_data,
   output logic      [VALUE_W-1:0] rd_data
);

   logic [VALUE_W-1:0] store_mem [DEPTH];
   logic [DEPTH-1:0]   valid_ff;
   logic [VALUE_W-1:0] rd_data_ff;
   logic               rd_hit_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   // An entry not written since reset or the last report reads as zero.
   always_ff @(posedge clock) begin
      if (reset || ctl.clear_all) begin
         valid_ff  <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         if (ctl.wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (ctl.rd_en) begin
            rd_hit_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_hit_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

### rtl/adc_two_bit_channel_statistics.sv
// Each item is taken in ST_IDLE, then 2*CHANNELS RAM reads follow (one per histogram entry and
// per offset sum) and a final step for the last write-back; the input is not ready before that.
// A report run sends 5*CHANNELS+1 items, each through a RAM read, a load and a send state.
// After the last update write, the first report item goes through ST_RPT_READ and ST_RPT_LOAD.
// Synchronous reset clears the counters, mask and RAM valid bits at once; no clearing pass.
`default_nettype none

module adc_two_bit_channel_statistics
   import adcstat_pkg::*;
#(
   parameter int CHANNELS = 4
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [WORD_W-1:0]   req_tdata,   // [15:0] sample_word
   input  wire logic                req_tlast,   // buffer_end
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [39:0]              rsp_tdata,   // [32:0] report_value, [39:33] zero
   output logic [4:0]               rsp_tuser,   // [4:0] report_slot
   output logic                     rsp_tlast,   // report_last
   input  wire logic                csr_we,
   input  wire logic [COUNT_W-1:0]  csr_wdata    // epoch_words
);

   `include "adc_two_bit_channel_statistics_defines.svh"

   localparam int DEPTH = 5 * CHANNELS;
   localparam int AW    = $clog2(DEPTH);
   localparam int KW    = $clog2(2 * CHANNELS + 1);
   localparam int CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [KW-1:0] K_END     = KW'(2 * CHANNELS);
   localparam logic [AW-1:0] OFS_BASE  = AW'(4 * CHANNELS);
   localparam logic [AW-1:0] MASK_SLOT = AW'(5 * CHANNELS);

   state_type           state_ff, state_in;
   logic [WORD_W-1:0]   word_ff, word_in;
   logic [WORD_W-1:0]   mask_ff, mask_in;
   logic [COUNT_W-1:0]  cnt_ff, cnt_in;
   logic [COUNT_W-1:0]  epoch_ff;
   logic                rpt_ff, rpt_in;
   logic [KW-1:0]       k_ff, k_in;
   logic                pend_ff, pend_in;
   logic                pend_ofs_ff, pend_ofs_in;
   logic [1:0]          pend_code_ff, pend_code_in;
   logic [AW-1:0]       pend_addr_ff, pend_addr_in;
   logic [AW-1:0]       slot_ff, slot_in;
   logic [VALUE_W-1:0]  value_ff, value_in;
   logic                last_ff, last_in;

   mem_ctl_type         mem_ctl;
   logic [AW-1:0]       rd_addr;
   logic [VALUE_W-1:0]  rd_data;
   logic [VALUE_W-1:0]  wr_data;

   logic [CHW-1:0]      ch;
   logic [1:0]          code;
   logic [COUNT_W-1:0]  cnt_sat;
   logic                rpt_hit;

   adcstat_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mem_ctl),
      .rd_addr (rd_addr),
      .wr_addr (pend_addr_ff),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff <= EPOCH_RESET;
      end else if (csr_we) begin
         epoch_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mask_ff  <= '0;
         cnt_ff   <= '0;
         rpt_ff   <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         mask_ff  <= mask_in;
         cnt_ff   <= cnt_in;
         rpt_ff   <= rpt_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff      <= word_in;
      k_ff         <= k_in;
      pend_ofs_ff  <= pend_ofs_in;
      pend_code_ff <= pend_code_in;
      pend_addr_ff <= pend_addr_in;
      slot_ff      <= slot_in;
      value_ff     <= value_in;
      last_ff      <= last_in;
   end

   // Even steps touch channel k/2's histogram entry, odd steps its offset sum.
   assign ch      = CHW'(k_ff >> 1);
   assign code    = 2'(word_ff >> (2 * int'(ch)));
   assign cnt_sat = (cnt_ff == CNT_MAX) ? cnt_ff : cnt_ff + 1'b1;
   assign rpt_hit = req_tlast && (cnt_sat >= epoch_ff);
   assign wr_data = pend_ofs_ff ? ofs_add(rd_data, pend_code_ff) : hist_inc(rd_data);

   always_comb begin
      state_in     = state_ff;
      word_in      = word_ff;
      mask_in      = mask_ff;
      cnt_in       = cnt_ff;
      rpt_in       = rpt_ff;
      k_in         = k_ff;
      pend_in      = 1'b0;
      pend_ofs_in  = pend_ofs_ff;
      pend_code_in = pend_code_ff;
      pend_addr_in = pend_addr_ff;
      slot_in      = slot_ff;
      value_in     = value_ff;
      last_in      = last_ff;
      mem_ctl      = '0;
      rd_addr      = slot_ff;
      req_tready   = 1'b0;
      rsp_tvalid   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               word_in  = req_tdata;
               mask_in  = mask_ff | req_tdata;
               cnt_in   = rpt_hit ? '0 : cnt_sat;
               rpt_in   = rpt_hit;
               k_in     = '0;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // All addresses of one item differ, so a write never meets a read of its entry.
            mem_ctl.wr_en = pend_ff;
            if (k_ff != K_END) begin
               mem_ctl.rd_en = 1'b1;
               rd_addr       = k_ff[0] ? OFS_BASE + AW'(ch) : AW'({ch, code});
               pend_in       = 1'b1;
               pend_ofs_in   = k_ff[0];
               pend_code_in  = code;
               pend_addr_in  = rd_addr;
               k_in          = k_ff + 1'b1;
            end else begin
               slot_in  = '0;
               state_in = rpt_ff ? ST_RPT_READ : ST_IDLE;
            end
         end
         ST_RPT_READ: begin
            mem_ctl.rd_en = (slot_ff != MASK_SLOT);
            state_in      = ST_RPT_LOAD;
         end
         ST_RPT_LOAD: begin
            if (slot_ff == MASK_SLOT) begin
               value_in = VALUE_W'(mask_ff);
               last_in  = 1'b1;
            end else begin
               value_in = rd_data;
               last_in  = 1'b0;
            end
            state_in = ST_RPT_SEND;
         end
         ST_RPT_SEND: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (last_ff) begin
                  mem_ctl.clear_all = 1'b1;
                  rpt_in            = 1'b0;
                  state_in          = ST_IDLE;
               end else begin
                  slot_in  = slot_ff + 1'b1;
                  state_in = ST_RPT_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tdata = {7'd0, value_ff};
   assign rsp_tuser = 5'(slot_ff);
   assign rsp_tlast = last_ff;

   `ADCSTAT_ASSERT_NOW(a_no_overlap, req_tready, !rsp_tvalid,
      "input accepted while a report item is pending")
   `ADCSTAT_ASSERT_NOW(a_last_is_mask, rsp_tvalid && rsp_tlast,
      rsp_tuser == 5'(5 * CHANNELS), "report run ends on a slot other than the mask")
   `ADCSTAT_ASSERT_NEXT(a_idle_after_run, rsp_tvalid && rsp_tready && rsp_tlast,
      req_tready && !rsp_tvalid, "block not idle after the end of a report run")

endmodule

`default_nettype wire

### tb/sv/adc_two_bit_channel_statistics_tb.sv
module adc_two_bit_channel_statistics_tb
   import adcstat_pkg::*;
();

   localparam int CHANNELS      = 4;
   localparam int CLOCK_PERIOD  = 4;
   localparam int OFFSET_SLOT0  = 4 * CHANNELS;
   localparam int MASK_SLOT     = 5 * CHANNELS;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_WORDS   = 39;
   localparam int RANDOM_PHASES = 11;
   localparam int CYCLE_LIMIT   = 5000000;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              buffer_end;
   } capture_item_type;

   typedef struct packed {
      logic [4:0]         slot;
      logic [VALUE_W-1:0] value;
      logic               last;
   } report_entry_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [WORD_W-1:0]   req_tdata  = '0;
   logic                req_tlast  = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [39:0]         rsp_tdata;
   logic [4:0]          rsp_tuser;
   logic                rsp_tlast;
   logic                csr_we     = 1'b0;
   logic [COUNT_W-1:0]  csr_wdata  = '0;

   capture_item_type pending_words[$];
   report_entry_type expected_reports[$];

   // Shadow copy of the statistics state.
   logic [COUNT_W-1:0]        epoch_len = EPOCH_RESET;
   logic [COUNT_W-1:0]        code_hist[4*CHANNELS];
   logic signed [VALUE_W-1:0] offset_acc[CHANNELS];
   logic [WORD_W-1:0]         activity_mask  = '0;
   logic [COUNT_W-1:0]        words_in_epoch = '0;

   int unsigned failures    = 0;
   int unsigned cycle_count = 0;
   int unsigned send_gap    = 0;
   int unsigned recv_gap    = 0;
   logic        send_quiet  = 1'b0;
   logic        recv_quiet  = 1'b0;

   initial begin
      foreach (code_hist[i]) code_hist[i] = '0;
      foreach (offset_acc[i]) offset_acc[i] = '0;
   end

   adc_two_bit_channel_statistics #(
      .CHANNELS(CHANNELS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),     // [15:0] sample_word
      .req_tlast(req_tlast),     // buffer_end
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),     // [32:0] report_value, [39:33] zero
      .rsp_tuser(rsp_tuser),     // [4:0] report_slot
      .rsp_tlast(rsp_tlast),     // report_last
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)      // epoch_words
   );

   always #(CLOCK_PERIOD/2) clock = ~clock;

   function automatic logic signed [VALUE_W:0] sample_level(input logic [1:0] code);
      logic signed [VALUE_W:0] level;
      case (code)
         CODE_P1: level = 34'sd1;
         CODE_P3: level = 34'sd3;
         CODE_M1: level = -34'sd1;
         default: level = -34'sd3;
      endcase
      return level;
   endfunction

   // Mostly short gaps, now and then a long one; none at all in a quiet stretch.
   function automatic int unsigned pick_gap(input logic quiet);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 50) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic tally_word(input logic [WORD_W-1:0] word, input logic buffer_end);
      logic [1:0]              code;
      logic signed [VALUE_W:0] total;
      report_entry_type        entry;
      for (int c = 0; c < CHANNELS; c++) begin
         code = word[2*c +: 2];
         if (code_hist[c*4 + code] != CNT_MAX) code_hist[c*4 + code]++;
         total = $signed({offset_acc[c][VALUE_W-1], offset_acc[c]}) + sample_level(code);
         if (total > OFS_MAX) total = OFS_MAX;
         else if (total < OFS_MIN) total = OFS_MIN;
         offset_acc[c] = total[VALUE_W-1:0];
      end
      activity_mask |= word;
      if (words_in_epoch != CNT_MAX) words_in_epoch++;
      if (buffer_end && words_in_epoch >= epoch_len) begin
         for (int i = 0; i < 4*CHANNELS; i++) begin
            entry = '{slot: 5'(i), value: VALUE_W'(code_hist[i]), last: 1'b0};
            expected_reports = {expected_reports, entry};
            code_hist[i] = '0;
         end
         for (int c = 0; c < CHANNELS; c++) begin
            entry = '{slot: 5'(OFFSET_SLOT0 + c), value: offset_acc[c], last: 1'b0};
            expected_reports = {expected_reports, entry};
            offset_acc[c] = '0;
         end
         // The mask is sticky across reports.
         entry = '{slot: 5'(MASK_SLOT), value: VALUE_W'(activity_mask), last: 1'b1};
         expected_reports = {expected_reports, entry};
         words_in_epoch = '0;
      end
   endtask

   always @(posedge clock) begin : drive_words
      capture_item_type next_item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            tally_word(req_tdata, req_tlast);
            if ($urandom_range(0, 31) == 0) send_quiet = !send_quiet;
            send_gap = pick_gap(send_quiet);
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap != 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               next_item = pending_words.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_item.word;
               req_tlast  <= next_item.buffer_end;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_reports
      report_entry_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_reports.size() == 0) begin
               $display({"%0t: unexpected report item: expected none, ",
                         "got slot %0d value %0h last %0b"},
                        $time, rsp_tuser, rsp_tdata, rsp_tlast);
               failures++;
            end else begin
               want = expected_reports.pop_front();
               if (rsp_tuser !== want.slot) begin
                  $display("%0t: report_slot mismatch: expected %0d, got %0d",
                           $time, want.slot, rsp_tuser);
                  failures++;
               end
               if (rsp_tdata !== {7'd0, want.value}) begin
                  $display("%0t: report_value mismatch in slot %0d: expected %0h, got %0h",
                           $time, want.slot, {7'd0, want.value}, rsp_tdata);
                  failures++;
               end
               if (rsp_tlast !== want.last) begin
                  $display("%0t: report_last mismatch in slot %0d: expected %0b, got %0b",
                           $time, want.slot, want.last, rsp_tlast);
                  failures++;
               end
            end
            if ($urandom_range(0, 31) == 0) recv_quiet = !recv_quiet;
            recv_gap = pick_gap(recv_quiet);
         end else if (!rsp_tvalid && recv_gap == 0 && $urandom_range(0, 15) == 0) begin
            recv_gap = pick_gap(recv_quiet);
         end
         if (recv_gap != 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("adc_two_bit_channel_statistics regression: fail");
         $finish;
      end
   end

   task automatic push_word(input logic [WORD_W-1:0] word, input logic buffer_end);
      capture_item_type item;
      item = '{word: word, buffer_end: buffer_end};
      pending_words = {pending_words, item};
   endtask

   // Holds the stimulus back until every item has gone in and every report has come out.
   task automatic settle();
      while (pending_words.size() != 0 || req_tvalid || expected_reports.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_epoch(input logic [COUNT_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      epoch_len = value;
      @(negedge clock);
   endtask

   initial begin : stimulus
      int unsigned     produced;
      int unsigned     run_len;
      logic [COUNT_W-1:0] epoch;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset epoch length is far away, so buffer ends do not report yet.
      push_word(16'h0000, 1'b1);
      push_word(16'hFFFF, 1'b1);
      push_word(16'h00E4, 1'b0);
      settle();

      write_epoch(CNT_MAX);
      push_word(16'h1B1B, 1'b1);
      push_word(16'h5555, 1'b0);
      settle();

      // A zero epoch length makes every buffer end report.
      write_epoch('0);
      push_word(16'hAAAA, 1'b1);
      push_word(16'hFF00, 1'b1);
      push_word(16'h00E4, 1'b1);
      settle();

      write_epoch(30'd3);
      push_word(16'h00FF, 1'b1);
      push_word(16'h8001, 1'b0);
      push_word(16'h0100, 1'b1);
      push_word(16'h0039, 1'b1);
      settle();

      write_epoch(30'd1);
      push_word(16'h00C6, 1'b1);
      push_word(16'hFFFF, 1'b0);
      push_word(16'h0000, 1'b1);
      settle();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 2) epoch = '0;
         else if (phase == 6) epoch = COUNT_W'($urandom_range(1000, CNT_MAX));
         else epoch = COUNT_W'($urandom_range(1, 12));
         write_epoch(epoch);
         produced = 0;
         while (produced < PHASE_WORDS) begin
            if ($urandom_range(0, 7) == 0) begin
               push_word(WORD_W'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)));
               produced++;
            end else begin
               run_len = $urandom_range(1, 6);
               for (int k = 0; k < run_len; k++)
                  push_word(WORD_W'($urandom_range(0, 16'hFFFF)), k == run_len - 1);
               produced += run_len;
            end
         end
         settle();
      end

      if (failures == 0) begin
         $display("adc_two_bit_channel_statistics regression: pass");
      end else begin
         $display("adc_two_bit_channel_statistics regression: fail");
      end
      $finish;
   end

endmodule
